[rtl/plvg_pkg.sv]
// plvg_pkg: shared types, constants, elaboration-time tables and helpers
// for the phong lobe value and gradient unit
// depends on nothing
package plvg_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int LOG_TABLE_BITS = 8;
  localparam int TAB_N          = 1 << LOG_TABLE_BITS;
  localparam int SHIN_FRAC      = 8;

  localparam logic [63:0] ONE_FX  = 64'd1 << FRAC_BITS;
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  localparam logic signed [23:0] S24_MAX = 24'sh7F_FFFF;
  localparam logic signed [23:0] S24_MIN = -24'sh80_0000;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_DIFFUSE  = 2'd0;
  localparam logic [1:0] CFG_SPECULAR = 2'd1;
  localparam logic [1:0] CFG_SHINE    = 2'd2;

  typedef logic [17:0] tab_t [0:TAB_N];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1+f) in fraction bits, by repeated squaring
  function automatic tab_t build_logt();
    tab_t t;
    logic [63:0] m;
    logic [63:0] r;
    for (int i = 0; i < TAB_N; i++) begin
      m = ONE_FX + ((64'(i) << FRAC_BITS) >> LOG_TABLE_BITS);
      r = '0;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        m = (m * m) >> FRAC_BITS;
        if (m >= 2 * ONE_FX) begin
          r = r | (64'd1 << (FRAC_BITS - k));
          m = m >> 1;
        end
      end
      t[i] = 18'(r);
    end
    t[TAB_N] = 18'(ONE_FX);
    return t;
  endfunction

  // 2^(i/TAB_N) from products of repeated square roots of two
  function automatic tab_t build_expt();
    tab_t t;
    logic [63:0] c [0:LOG_TABLE_BITS];
    logic [63:0] p;
    c[0] = 2 * ONE_FX;
    for (int k = 1; k <= LOG_TABLE_BITS; k++) c[k] = isqrt64(c[k-1] << FRAC_BITS);
    for (int i = 0; i < TAB_N; i++) begin
      p = ONE_FX;
      for (int k = 0; k < LOG_TABLE_BITS; k++)
        if (((i >> k) & 1) != 0) p = (p * c[LOG_TABLE_BITS - k]) >> FRAC_BITS;
      t[i] = 18'(p);
    end
    t[TAB_N] = 18'(2 * ONE_FX);
    return t;
  endfunction

  // saturate to signed 24 bits, clip flag on top
  function automatic logic [24:0] sat_s24(input logic signed [31:0] v);
    logic [24:0] res;
    if (v > 32'(S24_MAX)) res = {1'b1, S24_MAX};
    else if (v < 32'(S24_MIN)) res = {1'b1, S24_MIN};
    else res = {1'b0, v[23:0]};
    return res;
  endfunction

endpackage

[rtl/plvg_if.sv]
// plvg_in_if / plvg_out_if: valid-ready channels of the lobe unit
// depends on plvg_pkg
interface plvg_in_if;
  import plvg_pkg::*;
  logic        valid;
  logic        ready;
  logic [16:0] cosine;
  modport source (output valid, output cosine, input ready);
  modport sink (input valid, input cosine, output ready);
endinterface

interface plvg_out_if;
  import plvg_pkg::*;
  logic        valid;
  logic        ready;
  logic [23:0] lobe_value;
  logic [16:0] grad_gain;
  logic [23:0] grad_shininess;
  logic        clipped;
  modport source (output valid, output lobe_value, output grad_gain,
                  output grad_shininess, output clipped, input ready);
  modport sink (input valid, input lobe_value, input grad_gain,
                input grad_shininess, input clipped, output ready);
endinterface

[rtl/phong_lobe_value_and_gradient_unit.sv]
// phong_lobe_value_and_gradient_unit: kd + ks*x^n with gradients by ks and n
// each input beat yields one result beat, one beat per cycle sustained;
// the whole chain of 8 cells advances together and halts only while the
// result cell holds a beat that is not taken
// synchronous active-low reset empties the chain and loads kd=0, ks=1.0, n=1.0
// depends on plvg_pkg, plvg_if, plvg_cell
module phong_lobe_value_and_gradient_unit (
  input  logic        clk,
  input  logic        rst_n,
  plvg_in_if.sink     in_ch,
  plvg_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [23:0] cfg_wdata
);
  import plvg_pkg::*;

  localparam tab_t LOGT = build_logt();
  localparam tab_t EXPT = build_expt();

  // configuration registers
  logic signed [23:0] kd_r;
  logic signed [23:0] ks_r;
  logic [19:0]        n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kd_r <= 24'sd0;
      ks_r <= 24'sd65536;
      n_r  <= 20'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DIFFUSE:  kd_r <= cfg_wdata;
        CFG_SPECULAR: ks_r <= cfg_wdata;
        CFG_SHINE:    n_r  <= cfg_wdata[19:0];
        default:      ;  // unused index, write dropped
      endcase
    end
  end

  // payload of each cell
  typedef struct packed {
    logic        xz;
    logic [4:0]  p;
    logic [7:0]  lr;
    logic [17:0] lb;
    logic [17:0] ld;
  } s1_t;
  typedef struct packed {
    logic        xz;
    logic [20:0] q;
  } s2_t;
  typedef struct packed {
    logic        xz;
    logic [32:0] a;
    logic [20:0] lnq;
  } s3_t;
  typedef struct packed {
    logic        xz;
    logic [17:0] eb;
    logic [17:0] ed;
    logic [7:0]  er;
    logic        big;
    logic [4:0]  sh;
    logic [20:0] lnq;
  } s4_t;
  typedef struct packed {
    logic        xz;
    logic [16:0] pw;
    logic [20:0] lnq;
  } s5_t;
  typedef struct packed {
    logic               xz;
    logic [16:0]        pw;
    logic signed [41:0] kp;
    logic [21:0]        t;
  } s6_t;
  typedef struct packed {
    logic               xz;
    logic [16:0]        pw;
    logic signed [26:0] sv;
    logic signed [46:0] gp;
  } s7_t;
  typedef struct packed {
    logic [23:0] lobe;
    logic [16:0] pw;
    logic [23:0] grad;
    logic        clip;
  } s8_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;
  s7_t s7_d, s7_q;
  s8_t s8_d, s8_q;
  logic v1, v2, v3, v4, v5, v6, v7, v8;

  // the chain moves whenever the result cell is free or being drained
  logic adv;
  assign adv         = !v8 || out_ch.ready;
  assign in_ch.ready = adv;

  // cell 1: clamp, leading-one detect, log table read
  logic [16:0] xc;
  logic [4:0]  msb;
  logic [16:0] xn;
  logic [7:0]  li;
  always_comb begin
    xc = (in_ch.cosine > 17'd65536) ? 17'd65536 : in_ch.cosine;
    msb = 5'd0;
    for (int b = 0; b < 17; b++)
      if (xc[b]) msb = 5'(b);
    xn = 17'(xc << (5'd16 - msb));  // normalised mantissa in [1,2)
    li = xn[15:8];
    s1_d.xz = (xc == 17'd0);
    s1_d.p  = msb;
    s1_d.lr = xn[7:0];
    s1_d.lb = LOGT[{1'b0, li}];
    s1_d.ld = LOGT[{1'b0, li} + 9'd1] - LOGT[{1'b0, li}];
  end

  // cell 2: interpolate log2 and form -log2(x)
  logic [25:0] lprod;
  logic [16:0] lint;
  always_comb begin
    lprod   = s1_q.ld[17:0] * s1_q.lr;
    lint    = 17'(s1_q.lb + 18'(lprod >> 8));
    s2_d.xz = s1_q.xz;
    s2_d.q  = {5'd16 - s1_q.p, 16'd0} - {4'd0, lint};
  end

  // cell 3: exponent a = q*n and natural log magnitude, two parallel products
  logic [40:0] aprod;
  logic [52:0] lnprod;
  always_comb begin
    aprod    = s2_q.q * n_r;
    lnprod   = s2_q.q * LN2_Q32;
    s3_d.xz  = s2_q.xz;
    s3_d.a   = aprod[40:SHIN_FRAC];
    s3_d.lnq = lnprod[52:32];
  end

  // cell 4: exp2 table read on the fraction, shift from the integer part
  logic [16:0] ai;
  logic [16:0] et;
  logic [17:0] sh_full;
  always_comb begin
    ai      = s3_q.a[32:16];
    et      = 17'd65536 - {1'b0, s3_q.a[15:0]};
    sh_full = {1'b0, ai} + 18'd1;
    s4_d.xz  = s3_q.xz;
    s4_d.lnq = s3_q.lnq;
    if (et[16]) begin
      // top of the table, nothing to interpolate
      s4_d.eb = EXPT[TAB_N];
      s4_d.ed = 18'd0;
      s4_d.er = 8'd0;
    end else begin
      s4_d.eb = EXPT[{1'b0, et[15:8]}];
      s4_d.ed = EXPT[{1'b0, et[15:8]} + 9'd1] - EXPT[{1'b0, et[15:8]}];
      s4_d.er = et[7:0];
    end
    // mantissa is below 2^18, so a shift of 18 or more leaves nothing
    s4_d.big = (sh_full >= 18'd18);
    s4_d.sh  = sh_full[4:0];
  end

  // cell 5: interpolate exp2, shift down to x^n
  logic [25:0] eprod;
  logic [17:0] ev;
  always_comb begin
    eprod    = s4_q.ed * s4_q.er;
    ev       = s4_q.eb + 18'(eprod >> 8);
    s5_d.xz  = s4_q.xz;
    s5_d.lnq = s4_q.lnq;
    if (s4_q.xz) s5_d.pw = (n_r == 20'd0) ? 17'd65536 : 17'd0;
    else if (s4_q.big) s5_d.pw = 17'd0;
    else s5_d.pw = 17'(ev >> s4_q.sh);
  end

  // cell 6: ks*x^n and ln|x|*x^n
  logic [37:0] tprod;
  always_comb begin
    tprod   = s5_q.lnq * s5_q.pw;
    s6_d.xz = s5_q.xz;
    s6_d.pw = s5_q.pw;
    s6_d.kp = 42'(ks_r) * $signed({1'b0, s5_q.pw});
    s6_d.t  = tprod[37:16];
  end

  // cell 7: lobe sum and ks*t
  always_comb begin
    s7_d.xz = s6_q.xz;
    s7_d.pw = s6_q.pw;
    s7_d.sv = 27'(kd_r) + 27'($signed(s6_q.kp[41:16]));
    s7_d.gp = 47'(ks_r) * $signed({1'b0, s6_q.t});
  end

  // cell 8: negate, floor, saturate; the result cell
  logic signed [47:0] gneg;
  logic [24:0]        lsat;
  logic [24:0]        gsat;
  always_comb begin
    gneg = -48'(s7_q.gp);
    lsat = sat_s24(32'(s7_q.sv));
    gsat = sat_s24(gneg[47:16]);
    s8_d.lobe = lsat[23:0];
    s8_d.pw   = s7_q.pw;
    if (s7_q.xz) begin
      s8_d.grad = 24'd0;
      s8_d.clip = lsat[24];
    end else begin
      s8_d.grad = gsat[23:0];
      s8_d.clip = lsat[24] | gsat[24];
    end
  end

  plvg_cell #(.W($bits(s1_t))) u_c1 (.clk, .rst_n, .adv, .in_vld(in_ch.valid),
    .in_data(s1_d), .out_vld(v1), .out_data(s1_q));
  plvg_cell #(.W($bits(s2_t))) u_c2 (.clk, .rst_n, .adv, .in_vld(v1),
    .in_data(s2_d), .out_vld(v2), .out_data(s2_q));
  plvg_cell #(.W($bits(s3_t))) u_c3 (.clk, .rst_n, .adv, .in_vld(v2),
    .in_data(s3_d), .out_vld(v3), .out_data(s3_q));
  plvg_cell #(.W($bits(s4_t))) u_c4 (.clk, .rst_n, .adv, .in_vld(v3),
    .in_data(s4_d), .out_vld(v4), .out_data(s4_q));
  plvg_cell #(.W($bits(s5_t))) u_c5 (.clk, .rst_n, .adv, .in_vld(v4),
    .in_data(s5_d), .out_vld(v5), .out_data(s5_q));
  plvg_cell #(.W($bits(s6_t))) u_c6 (.clk, .rst_n, .adv, .in_vld(v5),
    .in_data(s6_d), .out_vld(v6), .out_data(s6_q));
  plvg_cell #(.W($bits(s7_t))) u_c7 (.clk, .rst_n, .adv, .in_vld(v6),
    .in_data(s7_d), .out_vld(v7), .out_data(s7_q));
  plvg_cell #(.W($bits(s8_t))) u_c8 (.clk, .rst_n, .adv, .in_vld(v7),
    .in_data(s8_d), .out_vld(v8), .out_data(s8_q));

  // result beat
  assign out_ch.valid          = v8;
  assign out_ch.lobe_value     = s8_q.lobe;
  assign out_ch.grad_gain      = s8_q.pw;
  assign out_ch.grad_shininess = s8_q.grad;
  assign out_ch.clipped        = s8_q.clip;

  // x^n never exceeds one
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.grad_gain <= 17'd65536)
    else $error("grad_gain above one");

  // a clip flag always comes with a rail value
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.clipped |->
      (out_ch.lobe_value == S24_MAX) || (out_ch.lobe_value == S24_MIN) ||
      (out_ch.grad_shininess == S24_MAX) || (out_ch.grad_shininess == S24_MIN))
    else $error("clipped without saturated output");

  // a stalled chain keeps the occupancy of cells 1 and 7 and a full result cell
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v7) && $stable(v1) && v8)
    else $error("chain moved while stalled");

  // an accepted beat is in the first cell next cycle
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1)
    else $error("accepted beat lost at entry");

endmodule

[rtl/plvg_cell.sv]
// plvg_cell: one pipeline cell, valid bit plus payload, moved on advance
// depends on nothing
module plvg_cell #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         in_vld,
  input  logic [W-1:0] in_data,
  output logic         out_vld,
  output logic [W-1:0] out_data
);

  logic         vld_r;
  logic [W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  // payload only loads with a live beat
  always_ff @(posedge clk) begin
    if (adv && in_vld) begin
      data_r <= in_data;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

[dv/tb.sv]
// tb: self-checking bench for phong_lobe_value_and_gradient_unit
// drives cosines over the valid-ready channels, mirrors kd + ks*x^n and both gradients
// depends on plvg_pkg, plvg_if and the unit itself
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plvg_pkg::*;

  localparam longint unsigned FX_ONE   = 64'd1 << 16;
  localparam longint unsigned LN2_FX32 = 64'hB172_17F8;
  localparam int              TBL_N    = 256;
  localparam logic [1:0]      CFG_UNUSED = 2'd3;   // no register behind this index
  localparam int              STALL_LIMIT = 5000;

  typedef struct packed {
    logic [23:0] lobe_value;
    logic [16:0] grad_gain;
    logic [23:0] grad_shininess;
    logic        clipped;
  } lobe_beat_t;

  typedef struct {
    logic [16:0] cosine;
    bit          typed;     // expected beat written out by hand
    lobe_beat_t  beat;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [23:0] cfg_wdata = '0;

  plvg_in_if  in_ch ();
  plvg_out_if out_ch ();

  phong_lobe_value_and_gradient_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // mirrored register file, reset values of the unit
  logic signed [23:0] mir_kd = 24'sd0;
  logic signed [23:0] mir_ks = 24'sd65536;
  logic [19:0]        mir_n  = 20'd256;

  longint unsigned log_tbl [0:TBL_N];
  longint unsigned pow_tbl [0:TBL_N];

  lobe_beat_t pending_beats [$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  logic in_acc, out_acc;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.cosine = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint unsigned sqrt_floor(input longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1+f) by repeated squaring, 2^(i/256) from chained square roots of two
  task automatic fill_tables();
    longint unsigned m, r, p;
    longint unsigned root [0:8];
    for (int i = 0; i < TBL_N; i++) begin
      m = FX_ONE + ((longint'(i) << 16) >> 8);
      r = 0;
      for (int k = 1; k <= 16; k++) begin
        m = (m * m) >> 16;
        if (m >= 2 * FX_ONE) begin
          r = r | (64'd1 << (16 - k));
          m = m >> 1;
        end
      end
      log_tbl[i] = r;
    end
    log_tbl[TBL_N] = FX_ONE;
    root[0] = 2 * FX_ONE;
    for (int k = 1; k <= 8; k++) root[k] = sqrt_floor(root[k-1] << 16);
    for (int i = 0; i < TBL_N; i++) begin
      p = FX_ONE;
      for (int k = 0; k < 8; k++)
        if (((i >> k) & 1) != 0) p = (p * root[8 - k]) >> 16;
      pow_tbl[i] = p;
    end
    pow_tbl[TBL_N] = 2 * FX_ONE;
  endtask

  // truncating linear interpolation, t in [0, 1.0]
  function automatic longint unsigned tbl_lerp(input bit use_pow, input longint unsigned t_in);
    longint unsigned t, i, r, lo, hi;
    t = (t_in > FX_ONE) ? FX_ONE : t_in;
    i = t >> 8;
    r = t & 255;
    if (i >= TBL_N) return use_pow ? pow_tbl[TBL_N] : log_tbl[TBL_N];
    lo = use_pow ? pow_tbl[i] : log_tbl[i];
    hi = use_pow ? pow_tbl[i+1] : log_tbl[i+1];
    return lo + (((hi - lo) * r) >> 8);
  endfunction

  function automatic logic [23:0] clamp_s24(input longint v, inout bit clip);
    if (v > 64'sd8388607) begin
      clip = 1'b1;
      return 24'h7F_FFFF;
    end
    if (v < -64'sd8388608) begin
      clip = 1'b1;
      return 24'h80_0000;
    end
    return v[23:0];
  endfunction

  // x^n through -log2 x and exp2, then value and both gradients
  function automatic lobe_beat_t lobe_predict(input logic [16:0] cos_in);
    longint unsigned x, q, a, ai, af, v, pw, lnq, tt;
    longint kd, ks, val, grad;
    int p;
    bit clip;
    lobe_beat_t res;
    kd = mir_kd;
    ks = mir_ks;
    x = (cos_in > FX_ONE) ? FX_ONE : cos_in;
    q = 0;
    grad = 0;
    clip = 1'b0;
    if (x == 0) begin
      pw = (mir_n == 0) ? FX_ONE : 0;
    end else begin
      p = 0;
      while ((x >> (p + 1)) != 0) p++;
      q = longint'(16 - p) * FX_ONE - tbl_lerp(1'b0, (x << (16 - p)) - FX_ONE);
      a = (q * mir_n) >> 8;
      ai = a >> 16;
      af = a & (FX_ONE - 1);
      v = tbl_lerp(1'b1, FX_ONE - af);
      pw = (ai + 1 >= 62) ? 0 : (v >> (ai + 1));
    end
    val = kd + ((ks * longint'(pw)) >>> 16);
    res.lobe_value = clamp_s24(val, clip);
    if (x != 0) begin
      lnq = (q * LN2_FX32) >> 32;
      tt = (lnq * pw) >> 16;
      grad = (-(ks * longint'(tt))) >>> 16;
      res.grad_shininess = clamp_s24(grad, clip);
    end else begin
      res.grad_shininess = '0;
    end
    res.grad_gain = pw[16:0];
    res.clipped = clip;
    return res;
  endfunction

  // sender pacing: bursts of random length, random gaps between them
  int burst_left = 0;

  task automatic send_cosine(input logic [16:0] c, input bit typed, input lobe_beat_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.cosine <= c;
    do @(posedge clk); while (!in_ch.ready);
    pending_beats.push_back(typed ? beat : lobe_predict(c));
  endtask

  // registers change only once the chain is empty
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    in_ch.valid <= 1'b0;
    wait (pending_beats.size() == 0);
    repeat (12) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DIFFUSE:  mir_kd = data;
      CFG_SPECULAR: mir_ks = data;
      CFG_SHINE:    mir_n  = data[19:0];
      default: ;
    endcase
  endtask

  function automatic logic [16:0] rand_cosine();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'($urandom_range(65537, 131071));   // clamped to one
      3:       return 17'($urandom_range(1, 255));          // deep in the log range
      4:       return 17'($urandom_range(60000, 65536));    // close to the peak
      default: return 17'($urandom_range(0, 131071));
    endcase
  endfunction

  // receiver: stall pattern rotates through always-ready, random, periodic and mostly-ready modes
  int rx_cyc = 0;
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    case ((rx_cyc / 200) % 4)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
      2:       out_ch.ready <= ((rx_cyc % 7) >= 3);
      default: out_ch.ready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    lobe_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        if (out_ch.lobe_value !== want.lobe_value) begin
          $error("lobe_value exp %h got %h", want.lobe_value, out_ch.lobe_value);
          fail_count++;
        end
        if (out_ch.grad_gain !== want.grad_gain) begin
          $error("grad_gain exp %h got %h", want.grad_gain, out_ch.grad_gain);
          fail_count++;
        end
        if (out_ch.grad_shininess !== want.grad_shininess) begin
          $error("grad_shininess exp %h got %h", want.grad_shininess, out_ch.grad_shininess);
          fail_count++;
        end
        if (out_ch.clipped !== want.clipped) begin
          $error("clipped exp %b got %b", want.clipped, out_ch.clipped);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    in_acc  = in_ch.valid && in_ch.ready;
    out_acc = out_ch.valid && out_ch.ready;
    if (in_acc || out_acc) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  stim_row_t directed [$];
  lobe_beat_t no_beat;

  initial begin
    no_beat = '0;
    fill_tables();
    // under reset registers: kd 0, ks 1.0, n 1.0
    directed.push_back('{17'd0,      1'b1, '{24'd0, 17'd0, 24'd0, 1'b0}});
    directed.push_back('{17'd65536,  1'b1, '{24'd65536, 17'd65536, 24'd0, 1'b0}});
    directed.push_back('{17'd131071, 1'b1, '{24'd65536, 17'd65536, 24'd0, 1'b0}});
    directed.push_back('{17'd65537,  1'b1, '{24'd65536, 17'd65536, 24'd0, 1'b0}});
    directed.push_back('{17'd1,      1'b0, no_beat});
    directed.push_back('{17'd2,      1'b0, no_beat});
    directed.push_back('{17'd3,      1'b0, no_beat});
    directed.push_back('{17'd256,    1'b0, no_beat});
    directed.push_back('{17'd1000,   1'b0, no_beat});
    directed.push_back('{17'd16384,  1'b0, no_beat});
    directed.push_back('{17'd32768,  1'b0, no_beat});
    directed.push_back('{17'd49152,  1'b0, no_beat});
    directed.push_back('{17'd65535,  1'b0, no_beat});
    directed.push_back('{17'h0AAAA,  1'b0, no_beat});
    directed.push_back('{17'h15555,  1'b0, no_beat});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_cosine(directed[i].cosine, directed[i].typed, directed[i].beat);

    // write to the unused index must leave every register alone
    write_reg(CFG_UNUSED, 24'hFF_FFFF);
    for (int i = 0; i < 20; i++) send_cosine(rand_cosine(), 1'b0, no_beat);

    // phases: extremes of each register first, then random settings
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_SHINE, 24'd0);               // x^n is one everywhere
        end
        1: begin
          write_reg(CFG_SHINE, 24'h0F_FFFF);         // huge exponent
          write_reg(CFG_SPECULAR, 24'h7F_FFFF);
        end
        2: begin
          write_reg(CFG_DIFFUSE, 24'h7F_FFFF);       // positive saturation
          write_reg(CFG_SHINE, 24'd128);
        end
        3: begin
          write_reg(CFG_DIFFUSE, 24'h80_0000);       // negative saturation
          write_reg(CFG_SPECULAR, 24'h80_0000);
        end
        4: begin
          write_reg(CFG_SPECULAR, 24'd0);
          write_reg(CFG_SHINE, 24'd1);
        end
        default: begin
          write_reg(CFG_DIFFUSE, 24'($urandom));
          write_reg(CFG_SPECULAR, 24'($urandom));
          write_reg(CFG_SHINE, ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 20'hF_FFFF))
                                                            : 24'($urandom_range(0, 4096)));
        end
      endcase
      for (int i = 0; i < 110; i++) send_cosine(rand_cosine(), 1'b0, no_beat);
    end

    in_ch.valid <= 1'b0;
    wait (pending_beats.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/plvg_pkg.sv
rtl/plvg_if.sv
rtl/plvg_cell.sv
rtl/phong_lobe_value_and_gradient_unit.sv
dv/tb.sv
